[design/trs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and register indexes for the triangular random sampler.
package trs_pkg;

   typedef struct packed {
      logic valid;
      logic degen;
      logic upper;
      logic zero_k;
   } trs_ctl_type;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PEAK_VALUE = 2'd2;

endpackage

[design/trs_front.sv]
`timescale 1ns / 1ps
// Setup pipeline: clamps the peak, picks the branch and forms the search bound.
module trs_front import trs_pkg::*; #(
   parameter int RANDOM_BITS = 16,
   parameter int VALUE_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [RANDOM_BITS-1:0]              in_word,
   input  logic [VALUE_BITS-1:0]               range_low,
   input  logic [VALUE_BITS-1:0]               range_high,
   input  logic [VALUE_BITS-1:0]               peak_value,
   output trs_ctl_type                         ctl_o,
   output logic [VALUE_BITS-1:0]               lo_o,
   output logic [VALUE_BITS-1:0]               hi_o,
   output logic [VALUE_BITS-1:0]               d_o,
   output logic [RANDOM_BITS+2*VALUE_BITS+1:0] rhs_o
);

   localparam int PB = RANDOM_BITS + VALUE_BITS;
   localparam int W  = RANDOM_BITS + 2 * VALUE_BITS + 2;
   localparam logic [RANDOM_BITS-1:0] WORD_MAX = '1;

   // stage 0
   trs_ctl_type             ctl0_ff, ctl0_in;
   logic [RANDOM_BITS-1:0]  r0_ff;
   logic [VALUE_BITS-1:0]   lo0_ff, hi0_ff, d0_ff, a0_ff, b0_ff;
   logic [VALUE_BITS-1:0]   mode_in;
   // stage 1
   trs_ctl_type             ctl1_ff;
   logic [VALUE_BITS-1:0]   lo1_ff, hi1_ff, d1_ff, a1_ff, b1_ff;
   logic [PB-1:0]           rd1_ff, nrd1_ff, am1_ff;
   logic [PB-1:0]           rd1_in, nrd1_in, am1_in;
   // stage 2
   trs_ctl_type             ctl2_ff, ctl2_in;
   logic [VALUE_BITS-1:0]   lo2_ff, hi2_ff, d2_ff, f2_ff, f2_in;
   logic [PB-1:0]           op2_ff, op2_in;
   // stage 3
   trs_ctl_type             ctl3_ff;
   logic [VALUE_BITS-1:0]   lo3_ff, hi3_ff, d3_ff;
   logic [W-1:0]            rhs3_ff, rhs3_in;
   // stage 4
   trs_ctl_type             ctl4_ff, ctl4_in;
   logic [VALUE_BITS-1:0]   lo4_ff, hi4_ff, d4_ff;
   logic [W-1:0]            rhs4_ff;

   always_comb begin
      mode_in = peak_value;
      if (peak_value < range_low) begin
         mode_in = range_low;
      end else if (peak_value > range_high) begin
         mode_in = range_high;
      end
      ctl0_in       = '0;
      ctl0_in.valid = in_valid;
      ctl0_in.degen = (range_high <= range_low);
   end

   always_comb begin
      rd1_in  = PB'(r0_ff) * PB'(d0_ff);
      nrd1_in = PB'(WORD_MAX - r0_ff) * PB'(d0_ff);
      am1_in  = {a0_ff, {RANDOM_BITS{1'b0}}} - PB'(a0_ff);
   end

   always_comb begin
      ctl2_in       = ctl1_ff;
      ctl2_in.upper = !(rd1_ff < am1_ff);
      op2_in        = ctl2_in.upper ? nrd1_ff : rd1_ff;
      f2_in         = ctl2_in.upper ? b1_ff : a1_ff;
   end

   always_comb begin
      rhs3_in        = W'(op2_ff) * W'({f2_ff, 2'b00});
      ctl4_in        = ctl3_ff;
      ctl4_in.zero_k = ctl3_ff.upper && (rhs3_ff <= W'(WORD_MAX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (en) begin
         ctl0_ff <= ctl0_in;
         ctl1_ff <= ctl0_ff;
         ctl2_ff <= ctl2_in;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff   <= in_word;
         lo0_ff  <= range_low;
         hi0_ff  <= range_high;
         d0_ff   <= range_high - range_low;
         a0_ff   <= mode_in - range_low;
         b0_ff   <= range_high - mode_in;

         lo1_ff  <= lo0_ff;
         hi1_ff  <= hi0_ff;
         d1_ff   <= d0_ff;
         a1_ff   <= a0_ff;
         b1_ff   <= b0_ff;
         rd1_ff  <= rd1_in;
         nrd1_ff <= nrd1_in;
         am1_ff  <= am1_in;

         lo2_ff  <= lo1_ff;
         hi2_ff  <= hi1_ff;
         d2_ff   <= d1_ff;
         op2_ff  <= op2_in;
         f2_ff   <= f2_in;

         lo3_ff  <= lo2_ff;
         hi3_ff  <= hi2_ff;
         d3_ff   <= d2_ff;
         rhs3_ff <= rhs3_in;

         lo4_ff  <= lo3_ff;
         hi4_ff  <= hi3_ff;
         d4_ff   <= d3_ff;
         rhs4_ff <= rhs3_ff;
      end
   end

   assign ctl_o = ctl4_ff;
   assign lo_o  = lo4_ff;
   assign hi_o  = hi4_ff;
   assign d_o   = d4_ff;
   assign rhs_o = rhs4_ff;

endmodule

[design/trs_cell.sv]
`timescale 1ns / 1ps
// Search cell: tries one bit of the offset k against the bound and passes the item on.
module trs_cell import trs_pkg::*; #(
   parameter int RANDOM_BITS = 16,
   parameter int VALUE_BITS  = 12,
   parameter int BIT_POS     = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  trs_ctl_type                         ctl_i,
   input  logic [VALUE_BITS-1:0]               lo_i,
   input  logic [VALUE_BITS-1:0]               hi_i,
   input  logic [VALUE_BITS-1:0]               d_i,
   input  logic [RANDOM_BITS+2*VALUE_BITS+1:0] rhs_i,
   input  logic [VALUE_BITS-1:0]               k_i,
   output trs_ctl_type                         ctl_o,
   output logic [VALUE_BITS-1:0]               lo_o,
   output logic [VALUE_BITS-1:0]               hi_o,
   output logic [VALUE_BITS-1:0]               d_o,
   output logic [RANDOM_BITS+2*VALUE_BITS+1:0] rhs_o,
   output logic [VALUE_BITS-1:0]               k_o
);

   localparam int SQ_BITS = 2 * VALUE_BITS + 2;
   localparam int W       = RANDOM_BITS + SQ_BITS;
   localparam logic [VALUE_BITS-1:0] BIT_MASK = VALUE_BITS'(1) << BIT_POS;

   // square stage
   logic [VALUE_BITS-1:0]   cand_a;
   logic [VALUE_BITS-1:0]   odd_hi;
   logic [SQ_BITS-1:0]      odd_ext;
   logic [SQ_BITS-1:0]      sq_in;
   logic                    fit_in;
   trs_ctl_type             ctla_ff;
   logic [VALUE_BITS-1:0]   loa_ff, hia_ff, da_ff, ka_ff;
   logic [W-1:0]            rhsa_ff;
   logic [SQ_BITS-1:0]      sq_ff;
   logic                    fit_ff;
   // compare stage
   logic [VALUE_BITS-1:0]   cand_b;
   logic [W-1:0]            sqm;
   logic                    pass;
   logic [VALUE_BITS-1:0]   k_in;
   trs_ctl_type             ctlb_ff;
   logic [VALUE_BITS-1:0]   lob_ff, hib_ff, db_ff, kb_ff;
   logic [W-1:0]            rhsb_ff;

   always_comb begin
      cand_a  = k_i | BIT_MASK;
      odd_hi  = ctl_i.upper ? cand_a : cand_a - 1'b1;
      odd_ext = SQ_BITS'({odd_hi, 1'b1});
      sq_in   = odd_ext * odd_ext;
      fit_in  = (cand_a <= d_i);
   end

   always_comb begin
      cand_b = ka_ff | BIT_MASK;
      sqm    = {sq_ff, {RANDOM_BITS{1'b0}}} - W'(sq_ff);
      pass   = fit_ff && (ctla_ff.upper ? (sqm < rhsa_ff) : (sqm <= rhsa_ff));
      k_in   = pass ? cand_b : ka_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctla_ff <= '0;
         ctlb_ff <= '0;
      end else if (en) begin
         ctla_ff <= ctl_i;
         ctlb_ff <= ctla_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         loa_ff  <= lo_i;
         hia_ff  <= hi_i;
         da_ff   <= d_i;
         rhsa_ff <= rhs_i;
         ka_ff   <= k_i;
         sq_ff   <= sq_in;
         fit_ff  <= fit_in;

         lob_ff  <= loa_ff;
         hib_ff  <= hia_ff;
         db_ff   <= da_ff;
         rhsb_ff <= rhsa_ff;
         kb_ff   <= k_in;
      end
   end

   assign ctl_o = ctlb_ff;
   assign lo_o  = lob_ff;
   assign hi_o  = hib_ff;
   assign d_o   = db_ff;
   assign rhs_o = rhsb_ff;
   assign k_o   = kb_ff;

endmodule

[design/triangular_random_sampler.sv]
`timescale 1ns / 1ps
// Top level of the triangular random sampler: registers, search chain and output skid.
//
// Request channel: req_valid / req_stall carry one random word per beat; each
// beat yields exactly one rsp_sample beat on the response channel, in order.
// Configuration: csr_write_en with csr_index 0 (range low), 1 (range high) or
// 2 (peak) writes csr_wdata; other indexes are dropped. Write only when idle.
// Throughput: one beat per cycle while the response side keeps taking beats.
// Path from request beat to rsp_valid: five setup stages, a chain of VALUE_BITS
// search cells at two stages each (square, then compare), one result stage and
// the output register.
// Reset: clears all valid flags and loads range 0..4095 with peak 2048.
// Stall: when rsp_stall holds a waiting beat, the next result parks in a skid
// register and req_stall rises on the following cycle, freezing the pipe
// until the skid beat drains.
module triangular_random_sampler import trs_pkg::*; #(
   parameter int RANDOM_BITS = 16,
   parameter int VALUE_BITS  = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RANDOM_BITS-1:0]    req_random_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_BITS-1:0]     rsp_sample,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]     csr_wdata
);

   localparam int W = RANDOM_BITS + 2 * VALUE_BITS + 2;
   localparam logic [VALUE_BITS-1:0] HIGH_RESET = VALUE_BITS'(4095);
   localparam logic [VALUE_BITS-1:0] PEAK_RESET = VALUE_BITS'(2048);

   logic [VALUE_BITS-1:0] range_low_ff, range_high_ff, peak_value_ff;
   logic                  adv;
   logic                  accept;

   trs_ctl_type           ctl_c [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] lo_c  [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] hi_c  [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] d_c   [VALUE_BITS+1];
   logic [W-1:0]          rhs_c [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] k_c   [VALUE_BITS+1];

   logic [VALUE_BITS:0]   kk;
   logic [VALUE_BITS:0]   res;
   logic [VALUE_BITS-1:0] fin_sample_in, fin_sample_ff;
   logic                  fin_valid_ff;

   logic                  rsp_valid_in, rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_sample_in, rsp_sample_ff;
   logic                  skid_valid_in, skid_valid_ff;
   logic [VALUE_BITS-1:0] skid_sample_in, skid_sample_ff;

   assign adv    = !skid_valid_ff;
   assign accept = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= HIGH_RESET;
         peak_value_ff <= PEAK_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RANGE_LOW: begin
               range_low_ff <= csr_wdata;
            end
            CSR_RANGE_HIGH: begin
               range_high_ff <= csr_wdata;
            end
            CSR_PEAK_VALUE: begin
               peak_value_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   trs_front #(
      .RANDOM_BITS (RANDOM_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (accept),
      .in_word    (req_random_word),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .peak_value (peak_value_ff),
      .ctl_o      (ctl_c[0]),
      .lo_o       (lo_c[0]),
      .hi_o       (hi_c[0]),
      .d_o        (d_c[0]),
      .rhs_o      (rhs_c[0])
   );

   assign k_c[0] = '0;

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      trs_cell #(
         .RANDOM_BITS (RANDOM_BITS),
         .VALUE_BITS  (VALUE_BITS),
         .BIT_POS     (VALUE_BITS - 1 - i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .ctl_i (ctl_c[i]),
         .lo_i  (lo_c[i]),
         .hi_i  (hi_c[i]),
         .d_i   (d_c[i]),
         .rhs_i (rhs_c[i]),
         .k_i   (k_c[i]),
         .ctl_o (ctl_c[i+1]),
         .lo_o  (lo_c[i+1]),
         .hi_o  (hi_c[i+1]),
         .d_o   (d_c[i+1]),
         .rhs_o (rhs_c[i+1]),
         .k_o   (k_c[i+1])
      );
   end

   always_comb begin
      kk = {1'b0, k_c[VALUE_BITS]};
      if (ctl_c[VALUE_BITS].upper) begin
         kk = ctl_c[VALUE_BITS].zero_k ? '0 : kk + 1'b1;
         if (kk > {1'b0, d_c[VALUE_BITS]}) begin
            kk = {1'b0, d_c[VALUE_BITS]};
         end
         res = {1'b0, hi_c[VALUE_BITS]} - kk;
      end else begin
         res = {1'b0, lo_c[VALUE_BITS]} + kk;
      end
      if (res < {1'b0, lo_c[VALUE_BITS]}) begin
         res = {1'b0, lo_c[VALUE_BITS]};
      end
      if (res > {1'b0, hi_c[VALUE_BITS]}) begin
         res = {1'b0, hi_c[VALUE_BITS]};
      end
      if (ctl_c[VALUE_BITS].degen) begin
         fin_sample_in = hi_c[VALUE_BITS];
      end else begin
         fin_sample_in = res[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= ctl_c[VALUE_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_sample_ff <= fin_sample_in;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      skid_valid_in  = skid_valid_ff;
      skid_sample_in = skid_sample_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_sample_in = skid_sample_ff;
            skid_valid_in = 1'b0;
         end
      end else if (fin_valid_ff) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_valid_in  = 1'b1;
            skid_sample_in = fin_sample_ff;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = fin_sample_ff;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff  <= rsp_sample_in;
      skid_sample_ff <= skid_sample_in;
   end

   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule
